// ----- hdl/dec_pkg.sv -----
// ----------------------------------------------------------------------------
// dec_pkg
// Shared widths, types and helpers of the disc collision pipeline.
// ----------------------------------------------------------------------------
package dec_pkg;

  localparam int CoordW   = 24;
  localparam int FracBits = 8;
  localparam int MassW    = 12;
  localparam int RadW     = 11;
  localparam int RsumW    = RadW + 1;
  localparam int MagW     = RsumW;
  localparam int D2W      = 2 * MagW + 1;
  localparam int DistW    = (D2W + 1) / 2;
  localparam int Div1NumW = 2 * MagW + 1;
  localparam int Div1DenW = DistW + 1;
  localparam int Div1QW   = MagW;
  localparam int LW       = 15;
  localparam int DvW      = CoordW + 1;
  localparam int DotW     = DvW + LW + 1;
  localparam int L2W      = 28;
  localparam int MsumW    = MassW + 1;
  localparam int KW       = MsumW + LW;
  localparam int Div2NumW = 62;
  localparam int Div2DenW = MsumW + L2W;
  localparam int Div2QW   = 27;
  localparam int SatW     = CoordW + 6;

  localparam logic [MassW-1:0] MassMin = MassW'(1 << FracBits);
  localparam logic [MassW-1:0] MassMax = MassW'(10 << FracBits);

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [SatW-1:0] SatMax = SatW'(CoordMax);
  localparam logic signed [SatW-1:0] SatMin = SatW'(CoordMin);

  typedef struct packed {
    coord_t             pa_x;
    coord_t             pa_y;
    coord_t             pb_x;
    coord_t             pb_y;
    coord_t             va_x;
    coord_t             va_y;
    coord_t             vb_x;
    coord_t             vb_y;
    logic [MassW-1:0]   ma;
    logic [MassW-1:0]   mb;
    logic [RsumW-1:0]   rsum;
    logic [MagW-1:0]    adx;
    logic [MagW-1:0]    ady;
    logic               ndx;
    logic               ndy;
    logic               zdist;
    logic               nlx;
    logic               nly;
    logic               ndot;
    logic               lnz;
    logic               hit;
    logic               over;
  } side_t;

  function automatic logic [MassW-1:0] clamp_mass(input logic [MassW-1:0] m);
    logic [MassW-1:0] r;
    if (m < MassMin) r = MassMin;
    else if (m > MassMax) r = MassMax;
    else r = m;
    return r;
  endfunction

  function automatic coord_t sat_coord(input logic signed [SatW-1:0] v);
    coord_t r;
    if (v > SatMax) r = CoordMax;
    else if (v < SatMin) r = CoordMin;
    else r = v[CoordW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/disc_elastic_collision.sv -----
// ----------------------------------------------------------------------------
// disc_elastic_collision
// Collision test, separation and elastic velocity response for a disc pair.
// ----------------------------------------------------------------------------
// One transaction on the input channel carries a pair of discs (centre,
// velocity, mass and radius each, signed Q15.8 coordinates). One transaction
// on the output channel returns the collided and overlapped flags with the
// corrected centres and post-impact velocities of both discs.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// The pipeline has four input stages, a 13-stage square root, the
// numerator stage, a 12-stage divider for the push-apart, seven response
// stages, a 27-stage divider for the velocity terms and the output register.
// The pipeline takes a new pair every cycle while in_stall_o is low.
// When out_stall_i holds back a waiting result, the whole pipeline freezes
// and in_stall_o is raised; nothing is lost or repeated.
// Reset clears the valid bits of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
module disc_elastic_collision (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [23:0]         pos_a_x_i,
  input  logic signed [23:0]         pos_a_y_i,
  input  logic signed [23:0]         vel_a_x_i,
  input  logic signed [23:0]         vel_a_y_i,
  input  logic        [11:0]         mass_a_i,
  input  logic        [10:0]         radius_a_i,
  input  logic signed [23:0]         pos_b_x_i,
  input  logic signed [23:0]         pos_b_y_i,
  input  logic signed [23:0]         vel_b_x_i,
  input  logic signed [23:0]         vel_b_y_i,
  input  logic        [11:0]         mass_b_i,
  input  logic        [10:0]         radius_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       collided_o,
  output logic                       overlapped_o,
  output logic signed [23:0]         new_pos_a_x_o,
  output logic signed [23:0]         new_pos_a_y_o,
  output logic signed [23:0]         new_vel_a_x_o,
  output logic signed [23:0]         new_vel_a_y_o,
  output logic signed [23:0]         new_pos_b_x_o,
  output logic signed [23:0]         new_pos_b_y_o,
  output logic signed [23:0]         new_vel_b_x_o,
  output logic signed [23:0]         new_vel_b_y_o
);

  localparam int Lat = 4 + dec_pkg::DistW + 1 + dec_pkg::Div1QW + 7 + dec_pkg::Div2QW + 1;
  localparam int SideW = $bits(dec_pkg::side_t);

  logic           en;
  logic [Lat-1:0] v_q;

  assign en         = !(v_q[Lat-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], in_valid_i};
    end
  end

  // stage 1: capture, mass clamp, deltas
  dec_pkg::side_t side1_d, side1_q;
  logic signed [dec_pkg::DvW-1:0] dx1_d, dy1_d, dx1_q, dy1_q;

  always_comb begin
    side1_d      = '0;
    side1_d.pa_x = pos_a_x_i;
    side1_d.pa_y = pos_a_y_i;
    side1_d.pb_x = pos_b_x_i;
    side1_d.pb_y = pos_b_y_i;
    side1_d.va_x = vel_a_x_i;
    side1_d.va_y = vel_a_y_i;
    side1_d.vb_x = vel_b_x_i;
    side1_d.vb_y = vel_b_y_i;
    side1_d.ma   = dec_pkg::clamp_mass(mass_a_i);
    side1_d.mb   = dec_pkg::clamp_mass(mass_b_i);
    side1_d.rsum = dec_pkg::RsumW'(radius_a_i) + dec_pkg::RsumW'(radius_b_i);
    dx1_d = dec_pkg::DvW'(pos_b_x_i) - dec_pkg::DvW'(pos_a_x_i);
    dy1_d = dec_pkg::DvW'(pos_b_y_i) - dec_pkg::DvW'(pos_a_y_i);
  end

  // stage 2: magnitudes and box test
  dec_pkg::side_t side2_d, side2_q;
  logic [dec_pkg::DvW-1:0] adx2, ady2;
  logic near2_d, near2_q;

  always_comb begin
    side2_d     = side1_q;
    adx2        = dx1_q[dec_pkg::DvW-1] ? -dx1_q : dx1_q;
    ady2        = dy1_q[dec_pkg::DvW-1] ? -dy1_q : dy1_q;
    near2_d     = (adx2 <= dec_pkg::DvW'(side1_q.rsum)) &&
                  (ady2 <= dec_pkg::DvW'(side1_q.rsum));
    side2_d.adx = near2_d ? adx2[dec_pkg::MagW-1:0] : '0;
    side2_d.ady = near2_d ? ady2[dec_pkg::MagW-1:0] : '0;
    side2_d.ndx = dx1_q[dec_pkg::DvW-1];
    side2_d.ndy = dy1_q[dec_pkg::DvW-1];
  end

  // stage 3: squares
  logic [2*dec_pkg::MagW-1:0] sqx3_d, sqy3_d, r2_3_d, sqx3_q, sqy3_q, r2_3_q;
  dec_pkg::side_t side3_q;
  logic near3_q;

  assign sqx3_d = side2_q.adx * side2_q.adx;
  assign sqy3_d = side2_q.ady * side2_q.ady;
  assign r2_3_d = side2_q.rsum * side2_q.rsum;

  // stage 4: distance squared and contact flags
  logic [dec_pkg::D2W-1:0] d2_4_d, d2_4_q;
  dec_pkg::side_t side4_d, side4_q;

  always_comb begin
    d2_4_d       = dec_pkg::D2W'(sqx3_q) + dec_pkg::D2W'(sqy3_q);
    side4_d      = side3_q;
    side4_d.hit  = near3_q && (d2_4_d <= dec_pkg::D2W'(r2_3_q));
    side4_d.over = near3_q && (d2_4_d < dec_pkg::D2W'(r2_3_q));
  end

  logic [dec_pkg::DistW-1:0] root5;
  dec_pkg::side_t side_a;

  dec_isqrt #(.XW(dec_pkg::D2W), .RW(dec_pkg::DistW)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (d2_4_q),
    .root_o (root5)
  );

  dec_delay #(.W(SideW), .DEPTH(dec_pkg::DistW)) u_dly_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side4_q),
    .q_o   (side_a)
  );

  // stage 5: push-apart numerators
  logic [dec_pkg::RsumW-1:0]    rd5;
  logic [2*dec_pkg::MagW-1:0]   mx5, my5;
  logic [dec_pkg::Div1NumW-1:0] numx5_d, numy5_d, numx5_q, numy5_q;
  logic [dec_pkg::Div1DenW-1:0] den5_q;
  dec_pkg::side_t side5_d, side5_q;

  always_comb begin
    rd5           = side_a.rsum - root5[dec_pkg::RsumW-1:0];
    mx5           = side_a.adx * rd5;
    my5           = side_a.ady * rd5;
    numx5_d       = dec_pkg::Div1NumW'(mx5) + dec_pkg::Div1NumW'(root5);
    numy5_d       = dec_pkg::Div1NumW'(my5) + dec_pkg::Div1NumW'(root5);
    side5_d       = side_a;
    side5_d.zdist = (root5 == '0);
  end

  logic [dec_pkg::Div1QW-1:0] qx, qy;
  dec_pkg::side_t side_b;

  dec_div #(.NW(dec_pkg::Div1NumW), .DW(dec_pkg::Div1DenW), .QW(dec_pkg::Div1QW)) u_div_px (
    .clk_i (clk_i), .en_i (en), .num_i (numx5_q), .den_i (den5_q), .quo_o (qx)
  );

  dec_div #(.NW(dec_pkg::Div1NumW), .DW(dec_pkg::Div1DenW), .QW(dec_pkg::Div1QW)) u_div_py (
    .clk_i (clk_i), .en_i (en), .num_i (numy5_q), .den_i (den5_q), .quo_o (qy)
  );

  dec_delay #(.W(SideW), .DEPTH(dec_pkg::Div1QW)) u_dly_push (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side5_q),
    .q_o   (side_b)
  );

  // stage 6: separated centres
  logic [dec_pkg::RsumW:0]          half6;
  logic signed [dec_pkg::SatW-1:0]  qx6, qy6, px6, py6;
  dec_pkg::side_t side6_d, side6_q;

  always_comb begin
    half6   = ({1'b0, side_b.rsum} + 1'b1) >> 1;
    qx6     = dec_pkg::SatW'(qx);
    qy6     = dec_pkg::SatW'(qy);
    px6     = side_b.zdist ? dec_pkg::SatW'(half6) : (side_b.ndx ? -qx6 : qx6);
    py6     = side_b.zdist ? '0 : (side_b.ndy ? -qy6 : qy6);
    side6_d = side_b;
    if (side_b.over) begin
      side6_d.pa_x = dec_pkg::sat_coord(dec_pkg::SatW'(side_b.pa_x) - px6);
      side6_d.pa_y = dec_pkg::sat_coord(dec_pkg::SatW'(side_b.pa_y) - py6);
      side6_d.pb_x = dec_pkg::sat_coord(dec_pkg::SatW'(side_b.pb_x) + px6);
      side6_d.pb_y = dec_pkg::sat_coord(dec_pkg::SatW'(side_b.pb_y) + py6);
    end
  end

  // stage 7: line of impact and relative velocity
  logic signed [dec_pkg::DvW-1:0] lxf7, lyf7, axf7, ayf7;
  logic signed [dec_pkg::DvW-1:0] dvx7_d, dvy7_d, dvx7_q, dvy7_q;
  logic signed [dec_pkg::LW-1:0]  lx7_q, ly7_q;
  logic [dec_pkg::LW-1:0]         alx7_q, aly7_q;
  dec_pkg::side_t side7_d, side7_q;

  always_comb begin
    lxf7        = dec_pkg::DvW'(side6_q.pb_x) - dec_pkg::DvW'(side6_q.pa_x);
    lyf7        = dec_pkg::DvW'(side6_q.pb_y) - dec_pkg::DvW'(side6_q.pa_y);
    axf7        = lxf7[dec_pkg::DvW-1] ? -lxf7 : lxf7;
    ayf7        = lyf7[dec_pkg::DvW-1] ? -lyf7 : lyf7;
    dvx7_d      = dec_pkg::DvW'(side6_q.vb_x) - dec_pkg::DvW'(side6_q.va_x);
    dvy7_d      = dec_pkg::DvW'(side6_q.vb_y) - dec_pkg::DvW'(side6_q.va_y);
    side7_d     = side6_q;
    side7_d.nlx = lxf7[dec_pkg::DvW-1];
    side7_d.nly = lyf7[dec_pkg::DvW-1];
  end

  // stage 8: products
  logic signed [dec_pkg::DvW+dec_pkg::LW-1:0] pxx8_d, pyy8_d, pxx8_q, pyy8_q;
  logic [2*dec_pkg::LW-1:0]    sqlx8_d, sqly8_d, sqlx8_q, sqly8_q;
  logic [dec_pkg::KW-1:0]      kax8_d, kay8_d, kbx8_d, kby8_d;
  logic [dec_pkg::KW-1:0]      kax8_q, kay8_q, kbx8_q, kby8_q;
  logic [dec_pkg::MsumW-1:0]   msum8_q, two_ma8, two_mb8;
  dec_pkg::side_t side8_q;

  always_comb begin
    pxx8_d  = dvx7_q * lx7_q;
    pyy8_d  = dvy7_q * ly7_q;
    sqlx8_d = alx7_q * alx7_q;
    sqly8_d = aly7_q * aly7_q;
    two_ma8 = {side7_q.ma, 1'b0};
    two_mb8 = {side7_q.mb, 1'b0};
    kax8_d  = two_mb8 * alx7_q;
    kay8_d  = two_mb8 * aly7_q;
    kbx8_d  = two_ma8 * alx7_q;
    kby8_d  = two_ma8 * aly7_q;
  end

  // stage 9: dot product and squared length
  logic signed [dec_pkg::DotW-1:0] dot9_q;
  logic [dec_pkg::L2W-1:0]         l2_9_q;
  logic [dec_pkg::KW-1:0]          kax9_q, kay9_q, kbx9_q, kby9_q;
  logic [dec_pkg::MsumW-1:0]       msum9_q;
  dec_pkg::side_t side9_q;

  // stage 10: magnitude of dot and denominator
  logic [dec_pkg::DotW-1:0]        adot10_q;
  logic [dec_pkg::Div2DenW-1:0]    den10_q;
  logic [dec_pkg::KW-1:0]          kax10_q, kay10_q, kbx10_q, kby10_q;
  dec_pkg::side_t side10_d, side10_q;

  always_comb begin
    side10_d      = side9_q;
    side10_d.ndot = dot9_q[dec_pkg::DotW-1];
    side10_d.lnz  = (l2_9_q != '0);
  end

  // stage 11: numerators
  logic [dec_pkg::DotW+dec_pkg::KW-1:0] nax11, nay11, nbx11, nby11;
  logic [dec_pkg::Div2NumW-1:0]         nax11_q, nay11_q, nbx11_q, nby11_q;
  logic [dec_pkg::Div2DenW-1:0]         den11_q;
  dec_pkg::side_t side11_q;

  assign nax11 = adot10_q * kax10_q;
  assign nay11 = adot10_q * kay10_q;
  assign nbx11 = adot10_q * kbx10_q;
  assign nby11 = adot10_q * kby10_q;

  // stage 12: rounding offset
  logic [dec_pkg::Div2NumW-1:0] half12;
  logic [dec_pkg::Div2NumW-1:0] nax12_q, nay12_q, nbx12_q, nby12_q;
  logic [dec_pkg::Div2DenW-1:0] den12_q;
  dec_pkg::side_t side12_q;

  assign half12 = dec_pkg::Div2NumW'(den11_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q  <= side1_d;
      dx1_q    <= dx1_d;
      dy1_q    <= dy1_d;
      side2_q  <= side2_d;
      near2_q  <= near2_d;
      sqx3_q   <= sqx3_d;
      sqy3_q   <= sqy3_d;
      r2_3_q   <= r2_3_d;
      side3_q  <= side2_q;
      near3_q  <= near2_q;
      d2_4_q   <= d2_4_d;
      side4_q  <= side4_d;
      numx5_q  <= numx5_d;
      numy5_q  <= numy5_d;
      den5_q   <= {root5, 1'b0};
      side5_q  <= side5_d;
      side6_q  <= side6_d;
      lx7_q    <= lxf7[dec_pkg::LW-1:0];
      ly7_q    <= lyf7[dec_pkg::LW-1:0];
      alx7_q   <= axf7[dec_pkg::LW-1:0];
      aly7_q   <= ayf7[dec_pkg::LW-1:0];
      dvx7_q   <= dvx7_d;
      dvy7_q   <= dvy7_d;
      side7_q  <= side7_d;
      pxx8_q   <= pxx8_d;
      pyy8_q   <= pyy8_d;
      sqlx8_q  <= sqlx8_d;
      sqly8_q  <= sqly8_d;
      kax8_q   <= kax8_d;
      kay8_q   <= kay8_d;
      kbx8_q   <= kbx8_d;
      kby8_q   <= kby8_d;
      msum8_q  <= dec_pkg::MsumW'(side7_q.ma) + dec_pkg::MsumW'(side7_q.mb);
      side8_q  <= side7_q;
      dot9_q   <= dec_pkg::DotW'(pxx8_q) + dec_pkg::DotW'(pyy8_q);
      l2_9_q   <= sqlx8_q[dec_pkg::L2W-1:0] + sqly8_q[dec_pkg::L2W-1:0];
      kax9_q   <= kax8_q;
      kay9_q   <= kay8_q;
      kbx9_q   <= kbx8_q;
      kby9_q   <= kby8_q;
      msum9_q  <= msum8_q;
      side9_q  <= side8_q;
      adot10_q <= dot9_q[dec_pkg::DotW-1] ? -dot9_q : dot9_q;
      den10_q  <= msum9_q * l2_9_q;
      kax10_q  <= kax9_q;
      kay10_q  <= kay9_q;
      kbx10_q  <= kbx9_q;
      kby10_q  <= kby9_q;
      side10_q <= side10_d;
      nax11_q  <= nax11[dec_pkg::Div2NumW-1:0];
      nay11_q  <= nay11[dec_pkg::Div2NumW-1:0];
      nbx11_q  <= nbx11[dec_pkg::Div2NumW-1:0];
      nby11_q  <= nby11[dec_pkg::Div2NumW-1:0];
      den11_q  <= den10_q;
      side11_q <= side10_q;
      nax12_q  <= nax11_q + half12;
      nay12_q  <= nay11_q + half12;
      nbx12_q  <= nbx11_q + half12;
      nby12_q  <= nby11_q + half12;
      den12_q  <= den11_q;
      side12_q <= side11_q;
    end
  end

  logic [dec_pkg::Div2QW-1:0] q_ax, q_ay, q_bx, q_by;
  dec_pkg::side_t side_c;

  dec_div #(.NW(dec_pkg::Div2NumW), .DW(dec_pkg::Div2DenW), .QW(dec_pkg::Div2QW)) u_div_ax (
    .clk_i (clk_i), .en_i (en), .num_i (nax12_q), .den_i (den12_q), .quo_o (q_ax)
  );

  dec_div #(.NW(dec_pkg::Div2NumW), .DW(dec_pkg::Div2DenW), .QW(dec_pkg::Div2QW)) u_div_ay (
    .clk_i (clk_i), .en_i (en), .num_i (nay12_q), .den_i (den12_q), .quo_o (q_ay)
  );

  dec_div #(.NW(dec_pkg::Div2NumW), .DW(dec_pkg::Div2DenW), .QW(dec_pkg::Div2QW)) u_div_bx (
    .clk_i (clk_i), .en_i (en), .num_i (nbx12_q), .den_i (den12_q), .quo_o (q_bx)
  );

  dec_div #(.NW(dec_pkg::Div2NumW), .DW(dec_pkg::Div2DenW), .QW(dec_pkg::Div2QW)) u_div_by (
    .clk_i (clk_i), .en_i (en), .num_i (nby12_q), .den_i (den12_q), .quo_o (q_by)
  );

  dec_delay #(.W(SideW), .DEPTH(dec_pkg::Div2QW)) u_dly_vel (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side12_q),
    .q_o   (side_c)
  );

  // stage 13: velocity update and output register
  logic signed [dec_pkg::SatW-1:0] sax, say, sbx, sby;
  logic signed [dec_pkg::SatW-1:0] tax, tay, tbx, tby;
  logic                            negx, negy, apply;
  dec_pkg::coord_t                 nvax_d, nvay_d, nvbx_d, nvby_d;
  logic                            collided_q, overlapped_q;
  dec_pkg::coord_t                 npax_q, npay_q, npbx_q, npby_q;
  dec_pkg::coord_t                 nvax_q, nvay_q, nvbx_q, nvby_q;

  always_comb begin
    negx   = side_c.ndot ^ side_c.nlx;
    negy   = side_c.ndot ^ side_c.nly;
    apply  = side_c.hit && side_c.lnz;
    sax    = dec_pkg::SatW'(q_ax);
    say    = dec_pkg::SatW'(q_ay);
    sbx    = dec_pkg::SatW'(q_bx);
    sby    = dec_pkg::SatW'(q_by);
    tax    = negx ? -sax : sax;
    tay    = negy ? -say : say;
    tbx    = negx ? -sbx : sbx;
    tby    = negy ? -sby : sby;
    nvax_d = side_c.va_x;
    nvay_d = side_c.va_y;
    nvbx_d = side_c.vb_x;
    nvby_d = side_c.vb_y;
    if (apply) begin
      nvax_d = dec_pkg::sat_coord(dec_pkg::SatW'(side_c.va_x) + tax);
      nvay_d = dec_pkg::sat_coord(dec_pkg::SatW'(side_c.va_y) + tay);
      nvbx_d = dec_pkg::sat_coord(dec_pkg::SatW'(side_c.vb_x) - tbx);
      nvby_d = dec_pkg::sat_coord(dec_pkg::SatW'(side_c.vb_y) - tby);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      collided_q   <= side_c.hit;
      overlapped_q <= side_c.over;
      npax_q       <= side_c.pa_x;
      npay_q       <= side_c.pa_y;
      npbx_q       <= side_c.pb_x;
      npby_q       <= side_c.pb_y;
      nvax_q       <= nvax_d;
      nvay_q       <= nvay_d;
      nvbx_q       <= nvbx_d;
      nvby_q       <= nvby_d;
    end
  end

  assign collided_o    = collided_q;
  assign overlapped_o  = overlapped_q;
  assign new_pos_a_x_o = npax_q;
  assign new_pos_a_y_o = npay_q;
  assign new_vel_a_x_o = nvax_q;
  assign new_vel_a_y_o = nvay_q;
  assign new_pos_b_x_o = npbx_q;
  assign new_pos_b_y_o = npby_q;
  assign new_vel_b_x_o = nvbx_q;
  assign new_vel_b_y_o = nvby_q;

  // overlap is a strict form of contact
  a_over_implies_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!overlapped_o || collided_o))
    else $error("overlapped without collided");

  // input is held back only by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // a frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(v_q))
    else $error("valid bits moved during stall");

endmodule

// ----- hdl/dec_delay.sv -----
// ----------------------------------------------------------------------------
// dec_delay
// Enabled shift line that carries side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module dec_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ----- hdl/dec_isqrt.sv -----
// ----------------------------------------------------------------------------
// dec_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module dec_isqrt #(
  parameter int XW = 25,
  parameter int RW = (XW + 1) / 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [XW-1:0] x_i,
  output logic [RW-1:0] root_o
);

  localparam int TW = XW + 2;

  logic [XW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int K = RW - 1 - i;
    logic [XW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [TW-1:0] term;
    logic [TW-1:0] diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in  = x_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign term = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
    assign ge   = TW'(rem_in) >= term;
    assign diff = TW'(rem_in) - term;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[XW-1:0] : rem_in;
        root_q[i] <= ge ? (root_in | (RW'(1) << K)) : root_in;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ----- hdl/dec_div.sv -----
// ----------------------------------------------------------------------------
// dec_div
// Pipelined restoring divider, one quotient bit per stage, floor result.
// ----------------------------------------------------------------------------
module dec_div #(
  parameter int NW = 25,
  parameter int DW = 14,
  parameter int QW = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] r_q  [QW];
  logic [QW-1:0] lo_q [QW];
  logic [QW-1:0] q_q  [QW];
  logic [DW-1:0] d_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign r_in  = DW'(num_i[NW-1:QW]);
      assign lo_in = num_i[QW-1:0];
      assign q_in  = '0;
      assign d_in  = den_i;
    end else begin : g_next
      assign r_in  = r_q[i-1];
      assign lo_in = lo_q[i-1];
      assign q_in  = q_q[i-1];
      assign d_in  = d_q[i-1];
    end

    assign t    = {r_in, lo_in[QW-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        lo_q[i] <= lo_in << 1;
        q_q[i]  <= {q_in[QW-2:0], ge};
        d_q[i]  <= d_in;
      end
    end
  end

  assign quo_o = q_q[QW-1];

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disc pair collision pipeline.
// ----------------------------------------------------------------------------
// Directed pairs cover the field extremes, contact and no-contact cases,
// coincident centres, zero radii, mass clamping and saturation. Random pairs
// follow, most of them placed near each other. Expected results are
// computed in the bench and compared field by field, in order, against each
// output transaction while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    dec_pkg::coord_t pax, pay, vax, vay;
    logic [dec_pkg::MassW-1:0] ma;
    logic [dec_pkg::RadW-1:0] ra;
    dec_pkg::coord_t pbx, pby, vbx, vby;
    logic [dec_pkg::MassW-1:0] mb;
    logic [dec_pkg::RadW-1:0] rb;
  } pair_t;

  typedef struct packed {
    logic hit, over;
    dec_pkg::coord_t pax, pay, vax, vay, pbx, pby, vbx, vby;
  } impact_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  pair_t drv;
  impact_t got;
  impact_t impact_q[$];
  int errors = 0;
  bit idle_off = 0;
  bit hold_out = 0;

  disc_elastic_collision i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_a_x_i(drv.pax), .pos_a_y_i(drv.pay), .vel_a_x_i(drv.vax),
    .vel_a_y_i(drv.vay), .mass_a_i(drv.ma), .radius_a_i(drv.ra),
    .pos_b_x_i(drv.pbx), .pos_b_y_i(drv.pby), .vel_b_x_i(drv.vbx),
    .vel_b_y_i(drv.vby), .mass_b_i(drv.mb), .radius_b_i(drv.rb),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .collided_o(got.hit), .overlapped_o(got.over),
    .new_pos_a_x_o(got.pax), .new_pos_a_y_o(got.pay),
    .new_vel_a_x_o(got.vax), .new_vel_a_y_o(got.vay),
    .new_pos_b_x_o(got.pbx), .new_pos_b_y_o(got.pby),
    .new_vel_b_x_o(got.vbx), .new_vel_b_y_o(got.vby)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(longint v);
    longint hi;
    hi = (longint'(1) << (dec_pkg::CoordW - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 60;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - r - b;
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  // round(a*b*c/d), ties away from zero, capped at 2^40
  function automatic longint ratio_round(longint a, longint b, longint c, longint d);
    bit neg;
    logic [127:0] n, q;
    neg = (a < 0) != (b < 0);
    n = 128'(absl(a)) * 128'(absl(b)) * 128'(c);
    q = (n + 128'(d / 2)) / 128'(d);
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mass_lim(logic [dec_pkg::MassW-1:0] m);
    if (m < dec_pkg::MassMin) return longint'(dec_pkg::MassMin);
    if (m > dec_pkg::MassMax) return longint'(dec_pkg::MassMax);
    return longint'(m);
  endfunction

  function automatic impact_t collide(pair_t p);
    impact_t r;
    longint ax, ay, bx, by, vax, vay, vbx, vby, ma, mb, rs, dx, dy;
    longint d2, r2, dist_lsb, px, py, lx, ly, l2, dot, den;
    bit hit, over;
    ax = p.pax; ay = p.pay; bx = p.pbx; by = p.pby;
    vax = p.vax; vay = p.vay; vbx = p.vbx; vby = p.vby;
    ma = mass_lim(p.ma); mb = mass_lim(p.mb);
    rs = longint'(p.ra) + longint'(p.rb);
    dx = bx - ax; dy = by - ay;
    hit = 0; over = 0;
    if (absl(dx) <= rs && absl(dy) <= rs) begin
      d2 = dx * dx + dy * dy;
      r2 = rs * rs;
      hit = d2 <= r2;
      over = d2 < r2;
      if (over) begin
        dist_lsb = root_floor(d2);
        if (dist_lsb == 0) begin
          px = (rs + 1) >> 1;
          py = 0;
        end else begin
          px = ratio_round(dx, rs - dist_lsb, 1, 2 * dist_lsb);
          py = ratio_round(dy, rs - dist_lsb, 1, 2 * dist_lsb);
        end
        ax = clip(ax - px); ay = clip(ay - py);
        bx = clip(bx + px); by = clip(by + py);
      end
    end
    if (hit) begin
      lx = bx - ax; ly = by - ay;
      l2 = lx * lx + ly * ly;
      if (l2 != 0) begin
        dot = (vbx - vax) * lx + (vby - vay) * ly;
        den = (ma + mb) * l2;
        r.vax = dec_pkg::coord_t'(clip(vax + ratio_round(dot, lx, 2 * mb, den)));
        r.vay = dec_pkg::coord_t'(clip(vay + ratio_round(dot, ly, 2 * mb, den)));
        r.vbx = dec_pkg::coord_t'(clip(vbx - ratio_round(dot, lx, 2 * ma, den)));
        r.vby = dec_pkg::coord_t'(clip(vby - ratio_round(dot, ly, 2 * ma, den)));
        vax = r.vax; vay = r.vay; vbx = r.vbx; vby = r.vby;
      end
    end
    r.hit = hit; r.over = over;
    r.pax = dec_pkg::coord_t'(ax); r.pay = dec_pkg::coord_t'(ay);
    r.pbx = dec_pkg::coord_t'(bx); r.pby = dec_pkg::coord_t'(by);
    r.vax = dec_pkg::coord_t'(vax); r.vay = dec_pkg::coord_t'(vay);
    r.vbx = dec_pkg::coord_t'(vbx); r.vby = dec_pkg::coord_t'(vby);
    return r;
  endfunction

  task automatic send_pair(pair_t p);
    int gap;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 12));
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    impact_q.insert(impact_q.size(), collide(p));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (impact_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    impact_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (impact_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = impact_q.pop_front();
        if (got.hit !== e.hit) begin $error("collided exp %0d got %0d", e.hit, got.hit); errors++; end
        if (got.over !== e.over) begin $error("overlapped exp %0d got %0d", e.over, got.over); errors++; end
        if (got.pax !== e.pax) begin $error("new_pos_a_x exp %0d got %0d", e.pax, got.pax); errors++; end
        if (got.pay !== e.pay) begin $error("new_pos_a_y exp %0d got %0d", e.pay, got.pay); errors++; end
        if (got.vax !== e.vax) begin $error("new_vel_a_x exp %0d got %0d", e.vax, got.vax); errors++; end
        if (got.vay !== e.vay) begin $error("new_vel_a_y exp %0d got %0d", e.vay, got.vay); errors++; end
        if (got.pbx !== e.pbx) begin $error("new_pos_b_x exp %0d got %0d", e.pbx, got.pbx); errors++; end
        if (got.pby !== e.pby) begin $error("new_pos_b_y exp %0d got %0d", e.pby, got.pby); errors++; end
        if (got.vbx !== e.vbx) begin $error("new_vel_b_x exp %0d got %0d", e.vbx, got.vbx); errors++; end
        if (got.vby !== e.vby) begin $error("new_vel_b_y exp %0d got %0d", e.vby, got.vby); errors++; end
      end
    end
  end

  // output stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
        hold_out = 0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        n = int'($urandom_range(1, 12));
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic dec_pkg::coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return dec_pkg::CoordMax;
      1: return dec_pkg::CoordMin;
      default: return dec_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair(bit near);
    pair_t p;
    int reach;
    p.ra = $urandom_range(0, 3) == 0 ? dec_pkg::RadW'($urandom)
                                     : dec_pkg::RadW'($urandom_range(1, 600));
    p.rb = $urandom_range(0, 3) == 0 ? dec_pkg::RadW'($urandom)
                                     : dec_pkg::RadW'($urandom_range(1, 600));
    p.ma = $urandom_range(0, 7) == 0 ? dec_pkg::MassW'($urandom)
                                     : dec_pkg::MassW'($urandom_range(256, 2560));
    p.mb = $urandom_range(0, 7) == 0 ? dec_pkg::MassW'($urandom)
                                     : dec_pkg::MassW'($urandom_range(256, 2560));
    p.pax = rand_coord(); p.pay = rand_coord();
    p.vax = rand_coord(); p.vay = rand_coord();
    p.vbx = rand_coord(); p.vby = rand_coord();
    if ($urandom_range(0, 1)) begin
      p.vax = dec_pkg::coord_t'($signed($urandom_range(0, 8191)) - 4096);
      p.vbx = dec_pkg::coord_t'($signed($urandom_range(0, 8191)) - 4096);
    end
    if (near) begin
      reach = int'(p.ra) + int'(p.rb) + 8;
      p.pbx = dec_pkg::coord_t'(clip(longint'(p.pax)
                                     + $signed($urandom_range(0, 2 * reach)) - reach));
      p.pby = dec_pkg::coord_t'(clip(longint'(p.pay)
                                     + $signed($urandom_range(0, 2 * reach)) - reach));
    end else begin
      p.pbx = rand_coord(); p.pby = rand_coord();
    end
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '0;
    p.ma = 12'd256; p.mb = 12'd2560; p.ra = 11'd512; p.rb = 11'd512;
    send_pair(p);                                    // coincident centres
    p.pbx = 24'sd1024; send_pair(p);                 // exact touch
    p.pbx = 24'sd1025; send_pair(p);                 // just apart
    p.pbx = 24'sd300; p.pby = -24'sd200; p.vax = 24'sd1000; p.vby = -24'sd700;
    send_pair(p);
    p.ra = 11'd0; p.rb = 11'd0; p.pbx = '0; p.pby = '0; send_pair(p);  // zero radii
    p.ra = 11'd2047; p.rb = 11'd2047; p.ma = 12'd0; p.mb = 12'hfff; send_pair(p);
    p.pax = dec_pkg::CoordMax; p.pay = dec_pkg::CoordMin;
    p.pbx = dec_pkg::CoordMax; p.pby = dec_pkg::CoordMin;
    send_pair(p);                                    // pushes clipped
    p.pbx = dec_pkg::CoordMax - 24'sd100; p.pby = dec_pkg::CoordMin + 24'sd50;
    p.vax = dec_pkg::CoordMax; p.vay = dec_pkg::CoordMin;
    p.vbx = dec_pkg::CoordMin; p.vby = dec_pkg::CoordMax;
    send_pair(p);                                    // velocity saturation
    p = '1; send_pair(p);
    p = '0; p.pax = dec_pkg::CoordMin; p.pbx = dec_pkg::CoordMax;
    p.ra = 11'd2047; p.rb = 11'd2047;
    send_pair(p);
    p.pax = -24'sd5; p.pbx = 24'sd5; p.pay = 24'sd7; p.pby = -24'sd7;
    p.ma = 12'd2560; p.mb = 12'd256;
    p.vax = -24'sd300; p.vbx = 24'sd300; send_pair(p);
    drain_results();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(rand_pair($urandom_range(0, 4) != 0));
  endtask

  task automatic test_backpressure();
    hold_out = 1;
    test_random(120);
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    idle_off = 1;
    test_random(250);
    drain_results();
    repeat (80) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
